### rtl/core/csr_spmv_pkg.sv
// Package for the CSR sparse matrix-vector multiply unit.
// Holds the transfer payload types, the item function codes and the result queue constants.
// No dependencies.
package csr_spmv_pkg;

    // Field widths fixed by the item format
    localparam int COL_W = 10;
    localparam int VAL_W = 32;
    localparam int ROW_W = 16;
    localparam int ACC_W = 64;

    // Result queue sizing
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = 3;
    localparam int OFIFO_CW    = 4;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_NONZERO = 2'd1,
        FUNC_EMPTY   = 2'd2
    } func_t;

    // Input item
    typedef struct packed {
        logic [1:0]              func;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
        logic                    row_end;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [VAL_W-1:0] row_sum;
        logic [ROW_W-1:0]        row_index;
        logic                    overflowed;
    } out_item_t;

    // Result queue status seen by the issue logic
    typedef struct packed {
        logic [OFIFO_CW-1:0] count;
    } ofifo_status_t;

endpackage

### rtl/core/csr_spmv_out_fifo.sv
// Result queue of the CSR sparse matrix-vector multiply unit.
// Small register queue that drives the m_ channel and reports its fill level.
// Depends on csr_spmv_pkg.
module csr_spmv_out_fifo
    import csr_spmv_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  out_item_t     push_data,
    output logic          m_valid,
    input  logic          m_ready,
    output out_item_t     m_data,
    output ofifo_status_t status
);

    out_item_t             entry_reg [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OFIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OFIFO_CW-1:0]   count_reg, count_next;
    logic                  pop;

    assign m_valid      = (count_reg != '0);
    assign m_data       = entry_reg[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign status.count = count_reg;

    // Pointer and fill level update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A push into a full queue would drop a result
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < OFIFO_CW'(OFIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    // Read and write pointers stay the fill level apart
    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill level");

endmodule

### rtl/core/csr_sparse_matrix_vector_multiply_unit.sv
// CSR sparse matrix-vector multiply unit (fixed point, Q16.16 in, Q32.32 accumulate).
// Top level: vector store, multiply-accumulate pipeline and rounding; uses csr_spmv_out_fifo.
// Depends on csr_spmv_pkg.
//
// Usage:
//   s_ channel (s_valid/s_ready/s_data) takes one item per transfer. A load item
//   writes value into the vector store at column. A nonzero item multiplies value
//   by the stored element of its column and adds the product into the row
//   accumulator; with row_end set it finishes the row. An empty-row item finishes
//   a row with a zero sum. Every column read must have been loaded before.
//   m_ channel (m_valid/m_ready/m_data) carries the rounded, saturated row sum,
//   its row number and the overflow flag, in row order.
// Path: a row-finishing item passes the store read, multiply and accumulate registers,
//   then the result queue, before it is shown on m_.
// Throughput: one item per cycle while s_ready is high, loads and nonzeros alike; the
//   single-port vector store and one multiplier each see at most one access per item.
// Stall: s_ready drops once results in the pipeline plus results queued reach
//   the 8-entry result queue; the pipeline itself never stops.
// Reset: clears the accumulator, the row counter and all valid state; the
//   vector store keeps no reset and must be loaded before use.
module csr_sparse_matrix_vector_multiply_unit
    import csr_spmv_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 65536
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int STORE_DEPTH = (MAX_COLS < (2 ** COL_W)) ? MAX_COLS : (2 ** COL_W);
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Vector store
    logic [VAL_W-1:0]        vec_mem [STORE_DEPTH];
    logic [VAL_W-1:0]        rd_data_reg;
    logic [STORE_AW-1:0]     mem_addr;
    logic                    mem_wr, mem_rd;

    // Issue signals
    logic                    s_xfer;
    logic                    col_ok;
    logic                    is_nonzero, is_empty, is_load;

    // Stage 1: store read
    logic                    v1_reg, v1_next;
    logic                    empty1_reg;
    logic                    last1_reg;
    logic                    colok1_reg;
    logic signed [VAL_W-1:0] val1_reg;

    // Stage 2: product
    logic                    v2_reg, v2_next;
    logic                    empty2_reg;
    logic                    last2_reg;
    logic signed [ACC_W-1:0] prod2_reg, prod2_next;
    logic signed [VAL_W-1:0] vec_elem;

    // Stage 3: finished row sum
    logic                    v3_reg, v3_next;
    logic signed [ACC_W-1:0] fin_reg, fin_next;

    // Accumulator and row counter
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W:0]          sum_wide;
    logic signed [ACC_W-1:0] sum_sat;
    logic [ROW_W-1:0]        row_cnt_reg, row_cnt_next;

    // Result path
    logic                    push;
    out_item_t               push_data;
    logic                    m_valid_int;
    ofifo_status_t           q_status;
    logic [OFIFO_CW-1:0]     pend;
    logic [OFIFO_CW:0]       credit_use;
    logic [ACC_W:0]          rnd_wide;
    logic [ACC_W-16:0]       rnd_q;

    // Input decode and credit check
    assign is_load    = (s_data.func == FUNC_LOAD);
    assign is_nonzero = (s_data.func == FUNC_NONZERO);
    assign is_empty   = (s_data.func == FUNC_EMPTY);
    assign col_ok     = (int'(s_data.column) < MAX_COLS);

    assign pend = OFIFO_CW'(v1_reg && (empty1_reg || last1_reg))
                + OFIFO_CW'(v2_reg && (empty2_reg || last2_reg))
                + OFIFO_CW'(v3_reg);
    assign credit_use = {1'b0, q_status.count} + {1'b0, pend};
    assign s_ready    = (credit_use < (OFIFO_CW + 1)'(OFIFO_DEPTH));
    assign s_xfer     = s_valid && s_ready;

    // Store port: write for loads, read for nonzeros
    assign mem_addr = s_data.column[STORE_AW-1:0];
    assign mem_wr   = s_xfer && is_load && col_ok;
    assign mem_rd   = s_xfer && is_nonzero;

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            vec_mem[mem_addr] <= s_data.value;
        end
        if (mem_rd) begin
            rd_data_reg <= vec_mem[mem_addr];
        end
    end

    // Stage valid bits
    always_comb begin
        v1_next = s_xfer && (is_nonzero || is_empty);
        v2_next = v1_reg;
        v3_next = v2_reg && (empty2_reg || last2_reg);
    end

    // Multiply: out-of-range columns read as zero
    assign vec_elem   = colok1_reg ? $signed(rd_data_reg) : '0;
    assign prod2_next = val1_reg * vec_elem;

    // Saturating accumulate, cleared when a row finishes
    assign sum_wide = {acc_reg[ACC_W-1], acc_reg} + {prod2_reg[ACC_W-1], prod2_reg};
    always_comb begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    always_comb begin
        acc_next = acc_reg;
        fin_next = fin_reg;
        if (v2_reg) begin
            if (empty2_reg) begin
                acc_next = '0;
                fin_next = '0;
            end else if (last2_reg) begin
                acc_next = '0;
                fin_next = sum_sat;
            end else begin
                acc_next = sum_sat;
            end
        end
    end

    // Round half up to Q16.16, then saturate to 32 bits
    assign rnd_wide = {fin_reg[ACC_W-1], fin_reg} + (ACC_W + 1)'(32'h8000);
    assign rnd_q    = rnd_wide[ACC_W:16];

    always_comb begin
        push_data.row_index = row_cnt_reg;
        if (rnd_q[ACC_W-16:VAL_W-1] == '0 || rnd_q[ACC_W-16:VAL_W-1] == '1) begin
            push_data.row_sum    = $signed(rnd_q[VAL_W-1:0]);
            push_data.overflowed = 1'b0;
        end else begin
            push_data.row_sum    = rnd_q[ACC_W-16] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                   : {1'b0, {(VAL_W-1){1'b1}}};
            push_data.overflowed = 1'b1;
        end
    end

    assign push = v3_reg;

    // Row counter wraps after the last row
    always_comb begin
        row_cnt_next = row_cnt_reg;
        if (push) begin
            if (int'(row_cnt_reg) == MAX_ROWS - 1) begin
                row_cnt_next = '0;
            end else begin
                row_cnt_next = row_cnt_reg + 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            acc_reg     <= '0;
            row_cnt_reg <= '0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            acc_reg     <= acc_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        empty1_reg <= is_empty;
        last1_reg  <= s_data.row_end;
        colok1_reg <= col_ok;
        val1_reg   <= s_data.value;
        empty2_reg <= empty1_reg;
        last2_reg  <= last1_reg;
        prod2_reg  <= prod2_next;
        fin_reg    <= fin_next;
    end

    csr_spmv_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_valid   (m_valid_int),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .status    (q_status)
    );

    assign m_valid = m_valid_int;

    // An empty-row transfer yields a result once it has passed the v1, v2 and v3 registers
    a_empty_row_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && is_empty) |-> ##3 push)
        else $error("empty row did not produce a result");

    // Queued plus in-flight results never exceed the queue depth
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_use <= (OFIFO_CW + 1)'(OFIFO_DEPTH))
        else $error("result credit exceeded");

    // Loads finish at the store and never enter the pipeline
    a_load_no_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && is_load) |=> !v1_reg)
        else $error("load entered the pipeline");

    // The accumulator is clear after every finished row
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && (empty2_reg || last2_reg)) |=> (acc_reg == '0))
        else $error("accumulator not cleared at row end");

endmodule
